### rtl/core/pbcs_pkg.sv
// pbcs_pkg: shared types, codes and arithmetic helpers for the PME B-spline
// charge spreading block. No dependencies.
package pbcs_pkg;

  localparam int WB  = 31;   // spline weight, unsigned Q1.30 (never above 1.0)
  localparam int QB  = 48;   // scaled charge magnitude, Q.32
  localparam int DRB = 30;   // offset within a cell, unsigned Q0.30
  localparam int CB  = 15;   // width of flat cell index ports
  localparam logic [WB-1:0] W_ONE = 31'h4000_0000;

  typedef enum logic [1:0] {
    CMD_SPREAD = 2'd0,
    CMD_READ   = 2'd1,
    CMD_RDCLR  = 2'd2
  } pbcs_cmd_e;

  localparam logic [2:0] REG_RECIP_XX     = 3'd0;
  localparam logic [2:0] REG_RECIP_YX     = 3'd1;
  localparam logic [2:0] REG_RECIP_YY     = 3'd2;
  localparam logic [2:0] REG_RECIP_ZX     = 3'd3;
  localparam logic [2:0] REG_RECIP_ZY     = 3'd4;
  localparam logic [2:0] REG_RECIP_ZZ     = 3'd5;
  localparam logic [2:0] REG_CHARGE_SCALE = 3'd6;

  typedef struct packed {
    logic [30:0] recip_xx;
    logic [31:0] recip_yx;
    logic [30:0] recip_yy;
    logic [31:0] recip_zx;
    logic [31:0] recip_zy;
    logic [30:0] recip_zz;
    logic [31:0] charge_scale;
  } pbcs_cfg_t;

  typedef struct packed {
    logic spread;
    logic clear;
    logic neg;
    logic skip;
    logic in_range;
  } pbcs_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pbcs_fifo_st_t;

  // magnitude times Q1.30 weight, truncated, modulo 2^64
  function automatic logic [63:0] mulw(input logic [63:0] mag, input logic [WB-1:0] w);
    logic [62:0] hp;
    logic [62:0] lp;
    hp = mag[63:32] * w;
    lp = mag[31:0] * w;
    return {hp[61:0], 2'b00} + 64'(lp[62:30]);
  endfunction

  // eight restoring steps of a division by a small divisor: {remainder, quotient byte}
  function automatic logic [10:0] div_byte(input logic [2:0] rem, input logic [7:0] din,
                                            input logic [2:0] d);
    logic [2:0] r;
    logic [3:0] t;
    logic [7:0] qb;
    r  = rem;
    qb = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, din[i]};
      if (t >= {1'b0, d}) begin
        r     = 3'(t - {1'b0, d});
        qb[i] = 1'b1;
      end else begin
        r = t[2:0];
      end
    end
    return {r, qb};
  endfunction

endpackage

### rtl/core/pme_bspline_charge_spread.sv
// pme_bspline_charge_spread: top level; configuration registers, front end,
// queue and grid engine. Depends on pbcs_pkg, pbcs_front, pbcs_fifo, pbcs_back.
//
// Usage: an input transaction (in_valid_i high, in_stall_o low) carries a
// command. Spread maps the position to the grid, forms order-P B-spline
// weights per axis and adds charge * wx * wy * wz into P^3 grid cells; read
// returns one cell; read-and-clear also zeroes it. Every transaction yields
// exactly one output transaction (out_valid_o high, out_stall_i low).
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must do so only while idle, as the block itself does not enforce it.
// A spread atom passes through the front end's coordinate products, cell
// location and, per axis, the weight recursion with two products and a
// division per weight; the front end takes no new transaction until it has
// pushed the current one, and while the output is not stalled it sets the
// sustained spread rate. The grid engine then reads and writes each of the
// P^3 cells (one read and one write port, read then write per cell).
// Reset: a clearing pass zeroes every grid cell while in_stall_o stays high.
// A stalled output holds; the two-entry queue lets the front end continue
// until it fills.
module pme_bspline_charge_spread #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32,
  parameter int SPLINE_ORDER = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] charge_i,
  input  logic [14:0] cell_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] cell_value_o,
  output logic [14:0] base_cell_o,
  output logic        skipped_o
);
  import pbcs_pkg::*;

  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int ZW = $clog2(GRID_Z);
  localparam int AW = $clog2(GRID_X * GRID_Y * GRID_Z);
  localparam int EW = $bits(pbcs_ctrl_t) + QB + XW + YW + ZW + CB + AW
                      + 3 * SPLINE_ORDER * WB;

  pbcs_cfg_t cfg_q;
  pbcs_fifo_st_t fifo_st;
  logic front_busy, clearing, acc, push, pop;
  logic [EW-1:0] entry_in, entry_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recip_xx     <= 31'd268435456;
      cfg_q.recip_yx     <= '0;
      cfg_q.recip_yy     <= 31'd268435456;
      cfg_q.recip_zx     <= '0;
      cfg_q.recip_zy     <= '0;
      cfg_q.recip_zz     <= 31'd268435456;
      cfg_q.charge_scale <= 32'd16777216;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RECIP_XX:     cfg_q.recip_xx     <= cfg_wdata_i[30:0];
        REG_RECIP_YX:     cfg_q.recip_yx     <= cfg_wdata_i;
        REG_RECIP_YY:     cfg_q.recip_yy     <= cfg_wdata_i[30:0];
        REG_RECIP_ZX:     cfg_q.recip_zx     <= cfg_wdata_i;
        REG_RECIP_ZY:     cfg_q.recip_zy     <= cfg_wdata_i;
        REG_RECIP_ZZ:     cfg_q.recip_zz     <= cfg_wdata_i[30:0];
        REG_CHARGE_SCALE: cfg_q.charge_scale <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = front_busy | clearing;
  assign acc        = in_valid_i & ~in_stall_o;

  pbcs_front #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .SPLINE_ORDER(SPLINE_ORDER)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .acc_i(acc),
    .command_i(command_i),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .pos_z_i(pos_z_i),
    .charge_i(charge_i),
    .cell_req_i(cell_req_i),
    .fifo_st_i(fifo_st),
    .busy_o(front_busy),
    .push_o(push),
    .entry_o(entry_in)
  );

  pbcs_fifo #(
    .W(EW)
  ) u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(entry_in),
    .pop_i(pop),
    .data_o(entry_out),
    .st_o(fifo_st)
  );

  pbcs_back #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .SPLINE_ORDER(SPLINE_ORDER)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .entry_i(entry_out),
    .fifo_st_i(fifo_st),
    .pop_o(pop),
    .clearing_o(clearing),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cell_value_o(cell_value_o),
    .base_cell_o(base_cell_o),
    .skipped_o(skipped_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_st.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty)
    else $error("queue pop while empty");

  a_skip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && skipped_o) |-> (cell_value_o == 64'd0))
    else $error("skipped spread reports a nonzero cell value");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!pop && !out_valid_o))
    else $error("activity during clearing pass");

endmodule

### rtl/core/pbcs_front.sv
// pbcs_front: takes transactions, maps positions to grid coordinates, scales the
// charge and builds B-spline weights per axis. Depends on pbcs_pkg.
module pbcs_front #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32,
  parameter int SPLINE_ORDER = 5,
  localparam int XW = $clog2(GRID_X),
  localparam int YW = $clog2(GRID_Y),
  localparam int ZW = $clog2(GRID_Z),
  localparam int CELLS = GRID_X * GRID_Y * GRID_Z,
  localparam int AW = $clog2(CELLS),
  localparam int EW = $bits(pbcs_pkg::pbcs_ctrl_t) + pbcs_pkg::QB + XW + YW + ZW
                      + pbcs_pkg::CB + AW + 3 * SPLINE_ORDER * pbcs_pkg::WB
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pbcs_pkg::pbcs_cfg_t     cfg_i,
  input  logic                    acc_i,
  input  logic [1:0]              command_i,
  input  logic [31:0]             pos_x_i,
  input  logic [31:0]             pos_y_i,
  input  logic [31:0]             pos_z_i,
  input  logic [31:0]             charge_i,
  input  logic [14:0]             cell_req_i,
  input  pbcs_pkg::pbcs_fifo_st_t fifo_st_i,
  output logic                    busy_o,
  output logic                    push_o,
  output logic [EW-1:0]           entry_o
);
  import pbcs_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE, F_MUL, F_LOC, F_AXIS, F_ROT, F_MA, F_MB, F_DIV, F_PUSH
  } state_e;

  localparam int FW = AW + CB;

  state_e state_q;
  logic [2:0] cnt_q;
  logic [31:0] px_q, py_q, pz_q, chg_q;
  logic [QB-1:0] tx_q, ty_q, tz_q, q_q;
  logic [XW-1:0] bx_q;
  logic [YW-1:0] by_q;
  logic [ZW-1:0] bz_q;
  logic [DRB-1:0] drx_q, dry_q, drz_q, drc_q;
  logic [CB-1:0] base_q;
  logic [AW-1:0] req_q;
  pbcs_ctrl_t ctrl_q;
  logic [1:0] axis_q;
  logic [3:0] j_q, m_q, rot_q;
  logic [SPLINE_ORDER-1:0][WB-1:0] wv_q, wx_q, wy_q, wz_q;
  logic [63:0] pa_q, acc_q, quo_q;
  logic [2:0] rem_q;

  logic signed [31:0] ma, mb;
  logic signed [63:0] mprod;
  logic [31:0] cmag;
  logic [63:0] cprod;
  logic [56:0] sx, sy, sz;
  logic [XW-1:0] bxn;
  logic [YW-1:0] byn;
  logic [ZW-1:0] bzn;
  logic [FW-1:0] flat_w, reqw;
  logic [DRB-1:0] drsel;
  logic [3:0] k, mp1;
  logic [32:0] aop, bop;
  logic [WB-1:0] wm1, wtop, newv;
  logic [63:0] pa_n, pb_n;
  logic [10:0] dv;
  logic [63:0] qfull;
  logic [SPLINE_ORDER-1:0][WB-1:0] wrot;

  always_comb begin
    case (cnt_q)
      3'd0:    begin ma = px_q; mb = {1'b0, cfg_i.recip_xx}; end
      3'd1:    begin ma = py_q; mb = cfg_i.recip_yx; end
      3'd2:    begin ma = pz_q; mb = cfg_i.recip_zx; end
      3'd3:    begin ma = py_q; mb = {1'b0, cfg_i.recip_yy}; end
      3'd4:    begin ma = pz_q; mb = cfg_i.recip_zy; end
      default: begin ma = pz_q; mb = {1'b0, cfg_i.recip_zz}; end
    endcase
    mprod = ma * mb;
    cmag  = chg_q[31] ? (~chg_q + 32'd1) : chg_q;
    cprod = cmag * cfg_i.charge_scale;

    sx  = 57'(tx_q) * 57'(GRID_X);
    sy  = 57'(ty_q) * 57'(GRID_Y);
    sz  = 57'(tz_q) * 57'(GRID_Z);
    bxn = sx[48 +: XW];
    byn = sy[48 +: YW];
    bzn = sz[48 +: ZW];
    flat_w = FW'(bxn) * FW'(GRID_Y * GRID_Z) + FW'(byn) * FW'(GRID_Z) + FW'(bzn);
    reqw   = FW'(cell_req_i);

    case (axis_q)
      2'd0:    drsel = drx_q;
      2'd1:    drsel = dry_q;
      default: drsel = drz_q;
    endcase

    k    = j_q - 4'd1 - m_q;
    mp1  = m_q + 4'd1;
    aop  = 33'({k, 30'b0}) + 33'(drc_q);
    bop  = 33'({mp1, 30'b0} - 34'(drc_q));
    wm1  = (m_q == 4'd0) ? '0 : wv_q[SPLINE_ORDER-2];
    wtop = wv_q[SPLINE_ORDER-1];
    pa_n = aop * wm1;
    pb_n = bop * wtop;

    dv    = div_byte(rem_q, acc_q[63:56], 3'(j_q - 4'd1));
    qfull = {quo_q[55:0], dv[7:0]};
    newv  = qfull[60:30];
    wrot  = {wv_q[SPLINE_ORDER-2:0], newv};
  end

  assign busy_o  = (state_q != F_IDLE);
  assign push_o  = (state_q == F_PUSH) && !fifo_st_i.full;
  assign entry_o = {ctrl_q, q_q, bx_q, by_q, bz_q, base_q, req_q, wx_q, wy_q, wz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      px_q    <= '0;
      py_q    <= '0;
      pz_q    <= '0;
      chg_q   <= '0;
      tx_q    <= '0;
      ty_q    <= '0;
      tz_q    <= '0;
      q_q     <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      bz_q    <= '0;
      drx_q   <= '0;
      dry_q   <= '0;
      drz_q   <= '0;
      drc_q   <= '0;
      base_q  <= '0;
      req_q   <= '0;
      ctrl_q  <= '0;
      axis_q  <= '0;
      j_q     <= '0;
      m_q     <= '0;
      rot_q   <= '0;
      wv_q    <= '0;
      wx_q    <= '0;
      wy_q    <= '0;
      wz_q    <= '0;
      pa_q    <= '0;
      acc_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (acc_i) begin
            px_q   <= pos_x_i;
            py_q   <= pos_y_i;
            pz_q   <= pos_z_i;
            chg_q  <= charge_i;
            tx_q   <= '0;
            ty_q   <= '0;
            tz_q   <= '0;
            cnt_q  <= '0;
            ctrl_q <= '0;
            base_q <= '0;
            req_q  <= reqw[AW-1:0];
            case (command_i)
              CMD_SPREAD: begin
                ctrl_q.spread <= 1'b1;
                state_q       <= F_MUL;
              end
              CMD_RDCLR: begin
                ctrl_q.clear    <= 1'b1;
                ctrl_q.in_range <= (reqw < FW'(CELLS));
                state_q         <= F_PUSH;
              end
              default: begin
                ctrl_q.in_range <= (reqw < FW'(CELLS));
                state_q         <= F_PUSH;
              end
            endcase
          end
        end
        F_MUL: begin
          case (cnt_q)
            3'd0, 3'd1, 3'd2: tx_q <= tx_q + mprod[QB-1:0];
            3'd3, 3'd4:       ty_q <= ty_q + mprod[QB-1:0];
            default:          tz_q <= tz_q + mprod[QB-1:0];
          endcase
          if (cnt_q == 3'd0) begin
            q_q         <= cprod[63:16];
            ctrl_q.neg  <= chg_q[31];
            ctrl_q.skip <= (cprod == 64'd0);
          end
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd5) state_q <= F_LOC;
        end
        F_LOC: begin
          bx_q   <= bxn;
          by_q   <= byn;
          bz_q   <= bzn;
          drx_q  <= sx[47:18];
          dry_q  <= sy[47:18];
          drz_q  <= sz[47:18];
          base_q <= flat_w[CB-1:0];
          axis_q <= '0;
          state_q <= ctrl_q.skip ? F_PUSH : F_AXIS;
        end
        F_AXIS: begin
          wv_q    <= '0;
          wv_q[0] <= W_ONE - WB'(drsel);
          wv_q[1] <= WB'(drsel);
          drc_q   <= drsel;
          j_q     <= 4'd3;
          rot_q   <= 4'(SPLINE_ORDER - 3);
          state_q <= F_ROT;
        end
        F_ROT: begin
          if (rot_q == 4'd0) begin
            m_q     <= j_q - 4'd1;
            state_q <= F_MA;
          end else begin
            wv_q  <= {wv_q[SPLINE_ORDER-2:0], wv_q[SPLINE_ORDER-1]};
            rot_q <= rot_q - 4'd1;
          end
        end
        F_MA: begin
          pa_q    <= pa_n;
          state_q <= F_MB;
        end
        F_MB: begin
          acc_q   <= pa_q + pb_n;
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= F_DIV;
        end
        F_DIV: begin
          acc_q <= {acc_q[55:0], 8'd0};
          rem_q <= dv[10:8];
          quo_q <= qfull;
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            wv_q <= wrot;
            if (m_q != 4'd0) begin
              m_q     <= m_q - 4'd1;
              state_q <= F_MA;
            end else if (j_q != 4'(SPLINE_ORDER)) begin
              j_q     <= j_q + 4'd1;
              rot_q   <= 4'(SPLINE_ORDER - 1) - j_q;
              state_q <= F_ROT;
            end else begin
              case (axis_q)
                2'd0:    wx_q <= wrot;
                2'd1:    wy_q <= wrot;
                default: wz_q <= wrot;
              endcase
              if (axis_q == 2'd2) begin
                state_q <= F_PUSH;
              end else begin
                axis_q  <= axis_q + 2'd1;
                state_q <= F_AXIS;
              end
            end
          end
        end
        F_PUSH: begin
          if (!fifo_st_i.full) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/pbcs_fifo.sv
// pbcs_fifo: two-entry queue between the front end and the grid engine.
// Depends on pbcs_pkg.
module pbcs_fifo #(
  parameter int W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [W-1:0]            data_i,
  input  logic                    pop_i,
  output logic [W-1:0]            data_o,
  output pbcs_pkg::pbcs_fifo_st_t st_o
);
  import pbcs_pkg::*;

  logic [W-1:0] buf_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign data_o   = buf_q[rp_q];
  assign st_o.full  = (cnt_q == 2'd2);
  assign st_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

### rtl/core/pbcs_back.sv
// pbcs_back: grid engine; owns the charge grid memory, runs the clearing pass,
// the read-modify-write spreading loop and cell reads. Depends on pbcs_pkg.
module pbcs_back #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32,
  parameter int SPLINE_ORDER = 5,
  localparam int XW = $clog2(GRID_X),
  localparam int YW = $clog2(GRID_Y),
  localparam int ZW = $clog2(GRID_Z),
  localparam int CELLS = GRID_X * GRID_Y * GRID_Z,
  localparam int AW = $clog2(CELLS),
  localparam int EW = $bits(pbcs_pkg::pbcs_ctrl_t) + pbcs_pkg::QB + XW + YW + ZW
                      + pbcs_pkg::CB + AW + 3 * SPLINE_ORDER * pbcs_pkg::WB
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [EW-1:0]           entry_i,
  input  pbcs_pkg::pbcs_fifo_st_t fifo_st_i,
  output logic                    pop_o,
  output logic                    clearing_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [63:0]             cell_value_o,
  output logic [14:0]             base_cell_o,
  output logic                    skipped_o
);
  import pbcs_pkg::*;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_QZ, B_QZX, B_ADD, B_WR, B_RD, B_RDD, B_DONE
  } state_e;

  localparam int OW = $clog2(SPLINE_ORDER);

  pbcs_ctrl_t e_ctrl;
  logic [QB-1:0] e_q;
  logic [XW-1:0] e_bx;
  logic [YW-1:0] e_by;
  logic [ZW-1:0] e_bz;
  logic [CB-1:0] e_base;
  logic [AW-1:0] e_req;
  logic [SPLINE_ORDER-1:0][WB-1:0] e_wx, e_wy, e_wz;

  state_e state_q;
  pbcs_ctrl_t ctrl_q;
  logic [63:0] q_q, qz_q, qzx_q, add_q;
  logic [XW-1:0] bx_q, xi_q;
  logic [YW-1:0] by_q, yi_q;
  logic [ZW-1:0] zi_q;
  logic [OW-1:0] ix_q, iy_q, iz_q;
  logic [SPLINE_ORDER-1:0][WB-1:0] wx_q, wy_q, wz_q;
  logic [AW-1:0] addr_q, req_q, clr_q;
  logic [63:0] res_val_q;
  logic [CB-1:0] res_base_q;
  logic res_skip_q;
  logic out_valid_q;
  logic [63:0] cell_value_q;
  logic [CB-1:0] base_cell_q;
  logic skipped_q;

  logic [63:0] grid_q [CELLS];
  logic [63:0] mem_rd_q;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra, addr_n;
  logic [63:0] mem_wd;

  always_comb begin
    {e_ctrl, e_q, e_bx, e_by, e_bz, e_base, e_req, e_wx, e_wy, e_wz} = entry_i;
  end

  assign addr_n = AW'(xi_q) * AW'(GRID_Y * GRID_Z) + AW'(yi_q) * AW'(GRID_Z) + AW'(zi_q);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = '0;
    mem_ra = (state_q == B_RD) ? req_q : addr_n;
    case (state_q)
      B_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
      end
      B_WR: begin
        mem_we = 1'b1;
        mem_wd = ctrl_q.neg ? (mem_rd_q - add_q) : (mem_rd_q + add_q);
      end
      B_RDD: begin
        mem_we = ctrl_q.clear && ctrl_q.in_range;
        mem_wa = req_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_q[mem_wa] <= mem_wd;
    mem_rd_q <= grid_q[mem_ra];
  end

  assign pop_o        = (state_q == B_IDLE) && !fifo_st_i.empty;
  assign clearing_o   = (state_q == B_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_value_q;
  assign base_cell_o  = base_cell_q;
  assign skipped_o    = skipped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_CLEAR;
      ctrl_q       <= '0;
      q_q          <= '0;
      qz_q         <= '0;
      qzx_q        <= '0;
      add_q        <= '0;
      bx_q         <= '0;
      by_q         <= '0;
      xi_q         <= '0;
      yi_q         <= '0;
      zi_q         <= '0;
      ix_q         <= '0;
      iy_q         <= '0;
      iz_q         <= '0;
      wx_q         <= '0;
      wy_q         <= '0;
      wz_q         <= '0;
      addr_q       <= '0;
      req_q        <= '0;
      clr_q        <= '0;
      res_val_q    <= '0;
      res_base_q   <= '0;
      res_skip_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      cell_value_q <= '0;
      base_cell_q  <= '0;
      skipped_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELLS - 1)) state_q <= B_IDLE;
        end
        B_IDLE: begin
          if (!fifo_st_i.empty) begin
            ctrl_q     <= e_ctrl;
            q_q        <= 64'(e_q);
            bx_q       <= e_bx;
            by_q       <= e_by;
            xi_q       <= e_bx;
            yi_q       <= e_by;
            zi_q       <= e_bz;
            ix_q       <= '0;
            iy_q       <= '0;
            iz_q       <= '0;
            wx_q       <= e_wx;
            wy_q       <= e_wy;
            wz_q       <= e_wz;
            req_q      <= e_req;
            res_val_q  <= '0;
            res_base_q <= e_base;
            res_skip_q <= e_ctrl.skip;
            if (!e_ctrl.spread)   state_q <= B_RD;
            else if (e_ctrl.skip) state_q <= B_DONE;
            else                  state_q <= B_QZ;
          end
        end
        B_QZ: begin
          qz_q    <= mulw(q_q, wz_q[0]);
          state_q <= B_QZX;
        end
        B_QZX: begin
          qzx_q   <= mulw(qz_q, wx_q[0]);
          state_q <= B_ADD;
        end
        B_ADD: begin
          add_q   <= mulw(qzx_q, wy_q[0]);
          addr_q  <= addr_n;
          state_q <= B_WR;
        end
        B_WR: begin
          wy_q <= {wy_q[0], wy_q[SPLINE_ORDER-1:1]};
          yi_q <= (yi_q == YW'(GRID_Y - 1)) ? '0 : yi_q + YW'(1);
          iy_q <= iy_q + OW'(1);
          state_q <= B_ADD;
          if (iy_q == OW'(SPLINE_ORDER - 1)) begin
            iy_q <= '0;
            yi_q <= by_q;
            wx_q <= {wx_q[0], wx_q[SPLINE_ORDER-1:1]};
            xi_q <= (xi_q == XW'(GRID_X - 1)) ? '0 : xi_q + XW'(1);
            ix_q <= ix_q + OW'(1);
            state_q <= B_QZX;
            if (ix_q == OW'(SPLINE_ORDER - 1)) begin
              ix_q <= '0;
              xi_q <= bx_q;
              wz_q <= {wz_q[0], wz_q[SPLINE_ORDER-1:1]};
              zi_q <= (zi_q == ZW'(GRID_Z - 1)) ? '0 : zi_q + ZW'(1);
              iz_q <= iz_q + OW'(1);
              state_q <= (iz_q == OW'(SPLINE_ORDER - 1)) ? B_DONE : B_QZ;
            end
          end
        end
        B_RD: state_q <= B_RDD;
        B_RDD: begin
          res_val_q  <= ctrl_q.in_range ? mem_rd_q : '0;
          res_base_q <= '0;
          res_skip_q <= 1'b0;
          state_q    <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            cell_value_q <= res_val_q;
            base_cell_q  <= res_base_q;
            skipped_q    <= res_skip_q;
            state_q      <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
